@@ src/eigen_2x2_solver_core_macros.svh @@
// Assertion macros shared by the eigen solver RTL.
// Each macro expects signals named clk and rst in the scope of its use.
`ifndef EIGEN_2X2_SOLVER_CORE_MACROS_SVH
`define EIGEN_2X2_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define E2S_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define E2S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/e2s_pkg.sv @@
// Shared widths, constants and sideband types of the 2x2 eigen solver.
// Used by every module of the solver; depends on nothing.
package e2s_pkg;

  localparam int MAG_W  = 35;  // magnitude of the discriminant
  localparam int ROOT_W = 18;  // floor square root of MAG_W bits
  localparam int NUM_W  = 27;  // signed dividend, Q8.8 difference times 256
  localparam int QMAG_W = 26;  // dividend and quotient magnitude
  localparam int DEN_W  = 16;  // divisor magnitude
  localparam int VEC_W  = 24;
  localparam int DET_W  = 33;
  localparam int LAM_W  = 18;
  localparam int IM_W   = 17;

  localparam logic signed [VEC_W-1:0] ONE_Q88 = 24'sd256;
  localparam logic signed [VEC_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [VEC_W-1:0] SAT_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    VM_ZERO,
    VM_QY,
    VM_QX,
    VM_UNIT_X,
    VM_UNIT_Y
  } vec_mode_t;

  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic signed [16:0]      trace;
    logic signed [15:0]      a;
    logic signed [15:0]      b;
    logic signed [15:0]      c;
    logic signed [15:0]      d;
    logic                    neg;
    logic                    sing;
    logic                    sym;
  } sq_side_t;

  typedef struct packed {
    logic signed [DET_W-1:0] det;
    logic signed [LAM_W-1:0] l1;
    logic signed [LAM_W-1:0] l2;
    logic [IM_W-1:0]         im;
    logic [1:0]              cnt;
    vec_mode_t               mode1;
    vec_mode_t               mode2;
    logic                    sing;
    logic                    sym;
  } dv_side_t;

endpackage

@@ src/e2s_front.sv @@
// Front stages: products, trace, determinant, discriminant and flags.
// Three register stages; uses e2s_pkg.
module e2s_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [15:0]          m00,
  input  logic signed [15:0]          m01,
  input  logic signed [15:0]          m10,
  input  logic signed [15:0]          m11,
  input  logic [7:0]                  tolerance,
  output logic                        vld,
  output logic [e2s_pkg::MAG_W-1:0]   mag,
  output e2s_pkg::sq_side_t           side
);

  logic v1, v2;
  logic signed [31:0] p_ad, p_bc;
  logic signed [16:0] tr1, tr2;
  logic signed [15:0] a1, b1, c1, d1, a2, b2, c2, d2;
  logic sym1, sym2;
  logic signed [32:0] det2;
  logic signed [33:0] tsq2;

  logic signed [16:0] bc_diff;
  logic [16:0]        bc_abs;
  logic signed [35:0] disc;
  logic signed [35:0] disc_abs;
  logic signed [32:0] det_abs;

  always_comb begin
    bc_diff  = 17'(m01) - 17'(m10);
    bc_abs   = bc_diff[16] ? 17'(-bc_diff) : 17'(bc_diff);
    disc     = 36'(tsq2) - (36'(det2) <<< 2);
    disc_abs = disc[35] ? -disc : disc;
    det_abs  = det2[32] ? -det2 : det2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      vld <= 1'b0;
    end else if (en) begin
      v1  <= in_valid;
      v2  <= v1;
      vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_ad <= m00 * m11;
      p_bc <= m01 * m10;
      tr1  <= 17'(m00) + 17'(m11);
      a1   <= m00;
      b1   <= m01;
      c1   <= m10;
      d1   <= m11;
      sym1 <= bc_abs <= 17'(tolerance);

      det2 <= 33'(p_ad) - 33'(p_bc);
      tsq2 <= tr1 * tr1;
      tr2  <= tr1;
      a2   <= a1;
      b2   <= b1;
      c2   <= c1;
      d2   <= d1;
      sym2 <= sym1;

      mag        <= disc_abs[e2s_pkg::MAG_W-1:0];
      side.det   <= det2;
      side.trace <= tr2;
      side.a     <= a2;
      side.b     <= b2;
      side.c     <= c2;
      side.d     <= d2;
      side.neg   <= disc[35];
      side.sing  <= unsigned'(det_abs) <= {17'b0, tolerance, 8'b0};
      side.sym   <= sym2;
    end
  end

endmodule

@@ src/e2s_sqrt.sv @@
// Pipelined floor square root of the discriminant magnitude, one root bit per stage.
// Carries the sideband alongside; uses e2s_pkg.
module e2s_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          vld_in,
  input  logic [e2s_pkg::MAG_W-1:0]     mag,
  input  e2s_pkg::sq_side_t             side_in,
  output logic                          vld_out,
  output logic [e2s_pkg::ROOT_W-1:0]    root,
  output e2s_pkg::sq_side_t             side_out
);

  localparam int N = e2s_pkg::ROOT_W;
  localparam int TW = e2s_pkg::MAG_W + 3;

  logic [e2s_pkg::MAG_W-1:0]  rem_q   [0:N-1];
  logic [N-1:0]               root_q  [0:N-1];
  e2s_pkg::sq_side_t          side_q  [0:N-1];
  logic                       vld_q   [0:N-1];

  logic [e2s_pkg::MAG_W-1:0]  src_rem  [0:N-1];
  logic [N-1:0]               src_root [0:N-1];
  logic [TW-1:0]              trial    [0:N-1];
  logic                       ge       [0:N-1];

  // Stage k decides root bit N-1-k; the remainder tracks value minus root squared.
  always_comb begin
    src_rem[0]  = mag;
    src_root[0] = '0;
    for (int k = 1; k < N; k++) begin
      src_rem[k]  = rem_q[k-1];
      src_root[k] = root_q[k-1];
    end
    for (int k = 0; k < N; k++) begin
      trial[k] = (TW'(src_root[k]) << (N - k)) + (TW'(1) << (2 * (N - 1 - k)));
      ge[k]    = TW'(src_rem[k]) >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= vld_in;
      for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < N; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < N; k++) begin
        if (ge[k]) begin
          rem_q[k]  <= src_rem[k] - trial[k][e2s_pkg::MAG_W-1:0];
          root_q[k] <= src_root[k] | (N'(1) << (N - 1 - k));
        end else begin
          rem_q[k]  <= src_rem[k];
          root_q[k] <= src_root[k];
        end
      end
    end
  end

  assign vld_out  = vld_q[N-1];
  assign root     = root_q[N-1];
  assign side_out = side_q[N-1];

endmodule

@@ src/e2s_div.sv @@
// Two-lane pipelined signed divider, one quotient bit per stage, with 24-bit saturation.
// Carries the sideband alongside; uses e2s_pkg.
module e2s_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                vld_in,
  input  logic signed [e2s_pkg::NUM_W-1:0]    num [0:1],
  input  logic signed [15:0]                  den [0:1],
  input  e2s_pkg::dv_side_t                   side_in,
  output logic                                vld_out,
  output logic signed [e2s_pkg::VEC_W-1:0]    quot [0:1],
  output e2s_pkg::dv_side_t                   side_out
);

  localparam int N  = e2s_pkg::QMAG_W;
  localparam int DW = e2s_pkg::DEN_W;

  // Operand stage: magnitudes and result sign.
  logic [N-1:0]      p_n   [0:1];
  logic [DW-1:0]     p_d   [0:1];
  logic              p_neg [0:1];
  e2s_pkg::dv_side_t p_side;
  logic              p_vld;

  logic [N-1:0]      n_q   [0:N-1][0:1];
  logic [DW-1:0]     d_q   [0:N-1][0:1];
  logic [DW:0]       rem_q [0:N-1][0:1];
  logic [N-1:0]      q_q   [0:N-1][0:1];
  logic              neg_q [0:N-1][0:1];
  e2s_pkg::dv_side_t side_q [0:N-1];
  logic              vld_q  [0:N-1];

  logic [N-1:0]      src_n   [0:N-1][0:1];
  logic [DW-1:0]     src_d   [0:N-1][0:1];
  logic [DW:0]       src_rem [0:N-1][0:1];
  logic [N-1:0]      src_q   [0:N-1][0:1];
  logic [DW:0]       sh      [0:N-1][0:1];
  logic              ge      [0:N-1][0:1];

  logic signed [e2s_pkg::NUM_W-1:0] n_abs [0:1];
  logic signed [16:0]               d_abs [0:1];
  logic signed [e2s_pkg::VEC_W-1:0] sat   [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      n_abs[l] = num[l][e2s_pkg::NUM_W-1] ? -num[l] : num[l];
      d_abs[l] = den[l][15] ? -17'(den[l]) : 17'(den[l]);
    end
    for (int l = 0; l < 2; l++) begin
      src_n[0][l]   = p_n[l];
      src_d[0][l]   = p_d[l];
      src_rem[0][l] = '0;
      src_q[0][l]   = '0;
    end
    for (int k = 1; k < N; k++) begin
      for (int l = 0; l < 2; l++) begin
        src_n[k][l]   = n_q[k-1][l];
        src_d[k][l]   = d_q[k-1][l];
        src_rem[k][l] = rem_q[k-1][l];
        src_q[k][l]   = q_q[k-1][l];
      end
    end
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 2; l++) begin
        sh[k][l] = {src_rem[k][l][DW-1:0], src_n[k][l][N-1-k]};
        ge[k][l] = sh[k][l] >= {1'b0, src_d[k][l]};
      end
    end
    // Truncated magnitude gets the sign back, then clamps to 24 bits.
    for (int l = 0; l < 2; l++) begin
      if (neg_q[N-1][l]) begin
        if (q_q[N-1][l] > N'(24'h800000)) sat[l] = e2s_pkg::SAT_MIN;
        else                              sat[l] = -($signed(q_q[N-1][l][e2s_pkg::VEC_W-1:0]));
      end else begin
        if (q_q[N-1][l] > N'(24'h7FFFFF)) sat[l] = e2s_pkg::SAT_MAX;
        else                              sat[l] = $signed(q_q[N-1][l][e2s_pkg::VEC_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld   <= 1'b0;
      vld_out <= 1'b0;
      for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      p_vld    <= vld_in;
      vld_q[0] <= p_vld;
      for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
      vld_out  <= vld_q[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side    <= side_in;
      side_q[0] <= p_side;
      for (int k = 1; k < N; k++) side_q[k] <= side_q[k-1];
      side_out  <= side_q[N-1];
      for (int l = 0; l < 2; l++) begin
        p_n[l]      <= n_abs[l][N-1:0];
        p_d[l]      <= d_abs[l][DW-1:0];
        p_neg[l]    <= num[l][e2s_pkg::NUM_W-1] ^ den[l][15];
        neg_q[0][l] <= p_neg[l];
        quot[l]     <= sat[l];
      end
      for (int k = 1; k < N; k++) begin
        for (int l = 0; l < 2; l++) neg_q[k][l] <= neg_q[k-1][l];
      end
      for (int k = 0; k < N; k++) begin
        for (int l = 0; l < 2; l++) begin
          n_q[k][l] <= src_n[k][l];
          d_q[k][l] <= src_d[k][l];
          if (ge[k][l]) begin
            rem_q[k][l] <= sh[k][l] - {1'b0, src_d[k][l]};
            q_q[k][l]   <= src_q[k][l] | (N'(1) << (N - 1 - k));
          end else begin
            rem_q[k][l] <= sh[k][l];
            q_q[k][l]   <= src_q[k][l];
          end
        end
      end
    end
  end

endmodule

@@ src/eigen_2x2_solver_core.sv @@
// Closed-form eigen analysis of a 2x2 Q8.8 matrix, fully pipelined.
// From input transfer to result it runs through 3 front stages, 18 square root
// stages (one root bit each), 2 eigenvalue and operand stages, 28 divider stages
// (one quotient bit each plus sign handling) and the output register.
// Throughput is one matrix per cycle; the whole pipeline holds when the result is not taken.
// Synchronous active-high reset clears all valid bits and sets tolerance to 0.
module eigen_2x2_solver_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] determinant,
  output logic signed [17:0] lambda_first_re,
  output logic signed [17:0] lambda_second_re,
  output logic [16:0]        imag_magnitude,
  output logic [1:0]         vector_count,
  output logic signed [23:0] vec_first_x,
  output logic signed [23:0] vec_first_y,
  output logic signed [23:0] vec_second_x,
  output logic signed [23:0] vec_second_y,
  output logic               is_singular,
  output logic               is_symmetric
);

  `include "eigen_2x2_solver_core_macros.svh"

  logic [7:0] tolerance;
  logic       en;

  logic                              fr_vld;
  logic [e2s_pkg::MAG_W-1:0]         fr_mag;
  e2s_pkg::sq_side_t                 fr_side;

  logic                              sq_vld;
  logic [e2s_pkg::ROOT_W-1:0]        sq_root;
  e2s_pkg::sq_side_t                 sq_side;

  // Eigenvalue stage.
  logic                              lm_vld;
  logic signed [e2s_pkg::LAM_W-1:0]  lm_l1, lm_l2;
  logic [e2s_pkg::IM_W-1:0]          lm_im;
  e2s_pkg::sq_side_t                 lm_side;

  // Divider operand stage.
  logic                              op_vld;
  logic signed [e2s_pkg::NUM_W-1:0]  op_num [0:1];
  logic signed [15:0]                op_den [0:1];
  e2s_pkg::dv_side_t                 op_side;

  logic                              dv_vld;
  logic signed [e2s_pkg::VEC_W-1:0]  dv_quot [0:1];
  e2s_pkg::dv_side_t                 dv_side;

  logic signed [19:0] tr_e, rt_e, sum_p, sum_m;
  logic signed [19:0] l1_c, l2_c;

  logic signed [18:0] lam_diff;
  logic [18:0]        lam_dabs;
  logic [15:0]        b_abs, c_abs;
  logic               use_b, use_c;
  logic [1:0]         cnt_c;
  logic signed [18:0] nd [0:1];

  logic signed [e2s_pkg::VEC_W-1:0] vx [0:1];
  logic signed [e2s_pkg::VEC_W-1:0] vy [0:1];
  e2s_pkg::vec_mode_t               md [0:1];

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  e2s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .m00       (m00),
    .m01       (m01),
    .m10       (m10),
    .m11       (m11),
    .tolerance (tolerance),
    .vld       (fr_vld),
    .mag       (fr_mag),
    .side      (fr_side)
  );

  e2s_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (fr_vld),
    .mag      (fr_mag),
    .side_in  (fr_side),
    .vld_out  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // Eigenvalues: halvings are arithmetic shifts, so they floor.
  always_comb begin
    tr_e  = 20'(sq_side.trace);
    rt_e  = $signed(20'(sq_root));
    sum_p = tr_e + rt_e;
    sum_m = tr_e - rt_e;
    l1_c  = sq_side.neg ? (tr_e >>> 1) : (sum_p >>> 1);
    l2_c  = sq_side.neg ? (tr_e >>> 1) : (sum_m >>> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lm_l1   <= l1_c[e2s_pkg::LAM_W-1:0];
      lm_l2   <= l2_c[e2s_pkg::LAM_W-1:0];
      lm_im   <= sq_side.neg ? sq_root[e2s_pkg::ROOT_W-1:1] : '0;
      lm_side <= sq_side;
    end
  end

  // Pick the divider operands and how each vector is assembled.
  always_comb begin
    lam_diff = 19'(lm_l1) - 19'(lm_l2);
    lam_dabs = lam_diff[18] ? 19'(-lam_diff) : 19'(lam_diff);
    b_abs    = lm_side.b[15] ? 16'(-lm_side.b) : 16'(lm_side.b);
    c_abs    = lm_side.c[15] ? 16'(-lm_side.c) : 16'(lm_side.c);
    use_b    = b_abs > 16'(tolerance);
    use_c    = c_abs > 16'(tolerance);
    if (lm_side.neg)                      cnt_c = 2'd0;
    else if (lam_dabs > 19'(tolerance))   cnt_c = 2'd2;
    else                                  cnt_c = 2'd1;
    nd[0] = use_b ? (19'(lm_l1) - 19'(lm_side.a)) : (19'(lm_l1) - 19'(lm_side.d));
    nd[1] = use_b ? (19'(lm_l2) - 19'(lm_side.a)) : (19'(lm_l2) - 19'(lm_side.d));
    if (cnt_c == 2'd0) begin
      md[0] = e2s_pkg::VM_ZERO;
      md[1] = e2s_pkg::VM_ZERO;
    end else begin
      md[0] = use_b ? e2s_pkg::VM_QY : (use_c ? e2s_pkg::VM_QX : e2s_pkg::VM_UNIT_X);
      if (cnt_c == 2'd2) begin
        md[1] = use_b ? e2s_pkg::VM_QY : (use_c ? e2s_pkg::VM_QX : e2s_pkg::VM_UNIT_Y);
      end else begin
        md[1] = e2s_pkg::VM_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        op_num[l] <= {nd[l], 8'b0};
        op_den[l] <= use_b ? lm_side.b : lm_side.c;
      end
      op_side.det   <= lm_side.det;
      op_side.l1    <= lm_l1;
      op_side.l2    <= lm_l2;
      op_side.im    <= lm_im;
      op_side.cnt   <= cnt_c;
      op_side.mode1 <= md[0];
      op_side.mode2 <= md[1];
      op_side.sing  <= lm_side.sing;
      op_side.sym   <= lm_side.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lm_vld <= 1'b0;
      op_vld <= 1'b0;
    end else if (en) begin
      lm_vld <= sq_vld;
      op_vld <= lm_vld;
    end
  end

  e2s_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (op_vld),
    .num      (op_num),
    .den      (op_den),
    .side_in  (op_side),
    .vld_out  (dv_vld),
    .quot     (dv_quot),
    .side_out (dv_side)
  );

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (l == 0 ? dv_side.mode1 : dv_side.mode2)
        e2s_pkg::VM_QY: begin
          vx[l] = e2s_pkg::ONE_Q88;
          vy[l] = dv_quot[l];
        end
        e2s_pkg::VM_QX: begin
          vx[l] = dv_quot[l];
          vy[l] = e2s_pkg::ONE_Q88;
        end
        e2s_pkg::VM_UNIT_X: begin
          vx[l] = e2s_pkg::ONE_Q88;
          vy[l] = '0;
        end
        e2s_pkg::VM_UNIT_Y: begin
          vx[l] = '0;
          vy[l] = e2s_pkg::ONE_Q88;
        end
        default: begin
          vx[l] = '0;
          vy[l] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      determinant      <= dv_side.det;
      lambda_first_re  <= dv_side.l1;
      lambda_second_re <= dv_side.l2;
      imag_magnitude   <= dv_side.im;
      vector_count     <= dv_side.cnt;
      vec_first_x      <= vx[0];
      vec_first_y      <= vy[0];
      vec_second_x     <= vx[1];
      vec_second_y     <= vy[1];
      is_singular      <= dv_side.sing;
      is_symmetric     <= dv_side.sym;
    end
  end

  `E2S_ASSERT_IMPL(a_count_range, out_valid, vector_count != 2'd3, "vector count out of range")
  `E2S_ASSERT_IMPL(a_complex_zero, out_valid && vector_count == 2'd0, vec_first_x == '0 && vec_first_y == '0 && vec_second_x == '0 && vec_second_y == '0, "complex pair with nonzero vectors")
  `E2S_ASSERT_IMPL(a_real_order, out_valid && vector_count != 2'd0, imag_magnitude == '0 && lambda_first_re >= lambda_second_re, "real pair misordered or imaginary")
  `E2S_ASSERT_NEXT(a_cfg_write, cfg_valid, tolerance == $past(cfg_data), "tolerance write lost")

endmodule

@@ sim/tb_eigen_2x2_solver_core.sv @@
// Self-checking testbench for eigen_2x2_solver_core: random and corner matrices,
// with a behavioral model of the eigen analysis predicting every result.
// Depends only on the solver RTL and its package e2s_pkg.
module tb_eigen_2x2_solver_core;

  typedef struct {
    logic signed [32:0] det;
    logic signed [17:0] l1;
    logic signed [17:0] l2;
    logic [16:0]        im;
    logic [1:0]         cnt;
    logic signed [23:0] v1x;
    logic signed [23:0] v1y;
    logic signed [23:0] v2x;
    logic signed [23:0] v2y;
    logic               sing;
    logic               sym;
  } eig_result_t;

  int errors = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  class eigen_scoreboard;
    eig_result_t pending[$];
    longint tol;

    function longint floor_half(longint x);
      return x >>> 1;
    endfunction

    function longint int_sqrt(longint v);
      longint r = 0;
      longint bt = 64'sd1 <<< 62;
      while (bt > v) bt = bt >>> 2;
      while (bt != 0) begin
        if (v >= r + bt) begin
          v = v - (r + bt);
          r = (r >>> 1) + bt;
        end else begin
          r = r >>> 1;
        end
        bt = bt >>> 2;
      end
      return r;
    endfunction

    function longint sat_quot(longint num, longint den);
      longint q = (-num * 256) / den;
      if (q > 8388607) q = 8388607;
      if (q < -8388608) q = -8388608;
      return q;
    endfunction

    function void vector_for(longint a, longint b, longint c, longint d, longint l,
                             bit second, output longint vx, output longint vy);
      if ((b < 0 ? -b : b) > tol) begin
        vx = 256;
        vy = sat_quot(a - l, b);
      end else if ((c < 0 ? -c : c) > tol) begin
        vy = 256;
        vx = sat_quot(d - l, c);
      end else if (!second) begin
        vx = 256;
        vy = 0;
      end else begin
        vx = 0;
        vy = 256;
      end
    endfunction

    function void note_matrix(logic signed [15:0] a16, b16, c16, d16);
      longint a = a16, b = b16, c = c16, d = d16;
      longint tr, det, disc, s, l1, l2, im, cnt, dl, bc;
      longint v1x = 0, v1y = 0, v2x = 0, v2y = 0;
      eig_result_t r;
      im = 0;
      tr = a + d;
      det = a * d - b * c;
      disc = tr * tr - 4 * det;
      if (disc >= 0) begin
        s = int_sqrt(disc);
        l1 = floor_half(tr + s);
        l2 = floor_half(tr - s);
        vector_for(a, b, c, d, l1, 1'b0, v1x, v1y);
        dl = l1 - l2;
        if ((dl < 0 ? -dl : dl) > tol) begin
          cnt = 2;
          vector_for(a, b, c, d, l2, 1'b1, v2x, v2y);
        end else begin
          cnt = 1;
        end
      end else begin
        l1 = floor_half(tr);
        l2 = l1;
        im = int_sqrt(-disc) >>> 1;
        cnt = 0;
      end
      bc = b - c;
      r.det = 33'(det); r.l1 = 18'(l1); r.l2 = 18'(l2); r.im = 17'(im); r.cnt = 2'(cnt);
      r.v1x = 24'(v1x); r.v1y = 24'(v1y); r.v2x = 24'(v2x); r.v2y = 24'(v2y);
      r.sing = (det < 0 ? -det : det) <= tol * 256;
      r.sym = (bc < 0 ? -bc : bc) <= tol;
      pending.insert(pending.size(), r);
    endfunction

    task check_result(eig_result_t g);
      eig_result_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding", 1, 0);
        return;
      end
      e = pending.pop_front();
      if (g.det !== e.det) report("determinant", 64'(g.det), 64'(e.det));
      if (g.l1 !== e.l1) report("lambda_first_re", 64'(g.l1), 64'(e.l1));
      if (g.l2 !== e.l2) report("lambda_second_re", 64'(g.l2), 64'(e.l2));
      if (g.im !== e.im) report("imag_magnitude", 64'(g.im), 64'(e.im));
      if (g.cnt !== e.cnt) report("vector_count", 64'(g.cnt), 64'(e.cnt));
      if (g.v1x !== e.v1x) report("vec_first_x", 64'(g.v1x), 64'(e.v1x));
      if (g.v1y !== e.v1y) report("vec_first_y", 64'(g.v1y), 64'(e.v1y));
      if (g.v2x !== e.v2x) report("vec_second_x", 64'(g.v2x), 64'(e.v2x));
      if (g.v2y !== e.v2y) report("vec_second_y", 64'(g.v2y), 64'(e.v2y));
      if (g.sing !== e.sing) report("is_singular", 64'(g.sing), 64'(e.sing));
      if (g.sym !== e.sym) report("is_symmetric", 64'(g.sym), 64'(e.sym));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [7:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic signed [15:0] m00 = 0, m01 = 0, m10 = 0, m11 = 0;
  logic out_valid, out_ready = 0;
  logic signed [32:0] determinant;
  logic signed [17:0] lambda_first_re, lambda_second_re;
  logic [16:0] imag_magnitude;
  logic [1:0] vector_count;
  logic signed [23:0] vec_first_x, vec_first_y, vec_second_x, vec_second_y;
  logic is_singular, is_symmetric;

  eigen_2x2_solver_core u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  eigen_scoreboard sb = new();
  bit calm = 0;         // no idling in the last part of the run
  bit long_hold = 0;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (150) @(posedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      eig_result_t g;
      g.det = determinant; g.l1 = lambda_first_re; g.l2 = lambda_second_re;
      g.im = imag_magnitude; g.cnt = vector_count;
      g.v1x = vec_first_x; g.v1y = vec_first_y;
      g.v2x = vec_second_x; g.v2y = vec_second_y;
      g.sing = is_singular; g.sym = is_symmetric;
      sb.check_result(g);
    end
  end

  task automatic send_matrix(input logic signed [15:0] a, b, c, d);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    m00 <= a; m01 <= b; m10 <= c; m11 <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_matrix(a, b, c, d);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [7:0] t);
    cfg_valid <= 1;
    cfg_data <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.tol = 64'(t);
  endtask

  function automatic logic signed [15:0] pick_entry(int range_sel);
    case (range_sel)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return $signed(16'($urandom_range(0, 2048))) - 16'sd1024;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic signed [15:0] a, b, c, d;
    int k, rs;
    for (k = 0; k < count; k++) begin
      rs = $urandom_range(0, 2);
      a = pick_entry(rs); b = pick_entry(rs); c = pick_entry(rs); d = pick_entry(rs);
      case ($urandom_range(0, 7))
        0: c = b;                              // symmetric
        1: begin b = 0; c = 0; end             // diagonal
        2: begin d = a; c = 0; end             // repeated eigenvalue
        3: begin c = 16'(b + $urandom_range(0, 6) - 3); d = a; end
        4: begin b = 16'($urandom_range(0, 3) - 1); end
        default: ;
      endcase
      send_matrix(a, b, c, d);
    end
  endtask

  initial begin
    logic [7:0] tols[5] = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd4};
    int p;
    sb.tol = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed corners at the reset tolerance.
    send_matrix(0, 0, 0, 0);
    send_matrix(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_matrix(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_matrix(-16'sd32768, 16'sh7FFF, -16'sd32768, 16'sh7FFF);
    send_matrix(16'sh7FFF, -16'sd32768, 16'sh7FFF, -16'sd32768);
    send_matrix(0, -16'sd32768, 16'sh7FFF, 0);
    send_matrix(256, 0, 0, 256);
    send_matrix(256, 256, 0, 256);
    send_matrix(0, 256, -256, 0);
    send_matrix(0, 1, -1, 0);
    send_matrix(0, 1, 0, 0);
    send_matrix(512, 256, 256, 512);
    send_matrix(256, 0, 0, 512);
    send_matrix(256, 0, 1, 512);
    send_matrix(1, 16'sh7FFF, 1, -16'sd32768);
    send_matrix(16'sh7FFF, 1, 16'sh7FFF, -16'sd32768);
    send_matrix(-1, -1, -1, -1);
    send_matrix(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
    drain();

    for (p = 0; p < 5; p++) begin
      write_tolerance(tols[p]);
      if (p == 0) begin
        send_matrix(0, 1, 2, 0);
        send_matrix(256, 1, 0, 257);
      end
      if (p == 2) begin
        // Fill the pipeline against a stalled receiver.
        long_hold = 1;
        random_phase(120);
      end
      if (p == 4) calm = 1;
      random_phase(p == 4 ? 250 : 360);
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
